// ----- rtl/core/ctsc_pkg.sv -----
// Shared types and constants for the chained table substitution cipher core.
package ctsc_pkg;

  // Side of the square key table; a power of two from 16 to 256.
  localparam int TABLE_SIDE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIDE);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int BYTE_W     = 8;
  localparam int DEPTH      = TABLE_SIDE * TABLE_SIDE;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_BEGIN   = 2'd1,
    OP_ENCRYPT = 2'd2,
    OP_DECRYPT = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ADDR_WRITE,
    ADDR_SEED,
    ADDR_ENC,
    ADDR_SCAN0,
    ADDR_SCAN_NEXT
  } addr_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ENC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic      latch_in;
    logic      mem_we;
    logic      mem_re;
    addr_sel_t addr_sel;
    logic      col_clr;
    logic      col_inc;
    logic      chain_ld;
    logic      res_enc;
    logic      res_hit;
    logic      res_miss;
    logic      out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;
    logic last_col;
  } status_t;

endpackage

// ----- rtl/core/ctsc_ctrl.sv -----
// Controller state machine: sequences table lookups, the decrypt scan and output hand-off.
module ctsc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [1:0]      in_opcode,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  ctsc_pkg::status_t status,
  output ctsc_pkg::cmd_t  cmd
);
  import ctsc_pkg::*;

  state_t  state_r, state_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;
  logic    out_free;
  opcode_t op;

  assign op        = opcode_t'(in_opcode);
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.addr_sel  = ADDR_WRITE;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.latch_in = 1'b1;
          unique case (op)
            OP_WRITE: begin
              cmd.mem_we = 1'b1;
            end
            OP_BEGIN: begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_SEED;
              state_nxt    = ST_LOAD;
            end
            OP_ENCRYPT: begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_ENC;
              state_nxt    = ST_ENC;
            end
            OP_DECRYPT: begin
              cmd.mem_re   = 1'b1;
              cmd.addr_sel = ADDR_SCAN0;
              cmd.col_clr  = 1'b1;
              state_nxt    = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_LOAD: begin
        cmd.chain_ld = 1'b1;
        state_nxt    = ST_IDLE;
      end
      ST_ENC: begin
        cmd.chain_ld = 1'b1;
        cmd.res_enc  = 1'b1;
        state_nxt    = ST_FINISH;
      end
      ST_SCAN: begin
        // read data belongs to the current column
        priority if (status.hit) begin
          cmd.chain_ld = 1'b1;
          cmd.res_hit  = 1'b1;
          state_nxt    = ST_FINISH;
        end else if (status.last_col) begin
          cmd.res_miss = 1'b1;
          state_nxt    = ST_FINISH;
        end else begin
          cmd.mem_re   = 1'b1;
          cmd.addr_sel = ADDR_SCAN_NEXT;
          cmd.col_inc  = 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/ctsc_datapath.sv -----
// Datapath: key table memory, chain symbol, scan column counter and result registers.
module ctsc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  ctsc_pkg::cmd_t    cmd,
  input  logic [7:0]        in_table_row,
  input  logic [7:0]        in_table_column,
  input  logic [7:0]        in_entry_value,
  input  logic [7:0]        in_seed,
  input  logic [7:0]        in_data_byte,
  output ctsc_pkg::status_t status,
  output logic [7:0]        out_byte,
  output logic              out_matched
);
  import ctsc_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic [ADDR_W-1:0] addr;

  logic [BYTE_W-1:0] chain_r, chain_nxt;
  logic [BYTE_W-1:0] data_r;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic [IDX_W-1:0]  col_plus;
  logic [BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic              res_match_r, res_match_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_match_r;

  assign col_plus = col_r + IDX_W'(1);

  // indices wrap to the table side by dropping upper bits
  always_comb begin
    unique case (cmd.addr_sel)
      ADDR_WRITE:     addr = {in_table_row[IDX_W-1:0], in_table_column[IDX_W-1:0]};
      ADDR_SEED:      addr = {in_seed[IDX_W-1:0], in_seed[IDX_W-1:0]};
      ADDR_ENC:       addr = {chain_r[IDX_W-1:0], in_data_byte[IDX_W-1:0]};
      ADDR_SCAN0:     addr = {chain_r[IDX_W-1:0], {IDX_W{1'b0}}};
      ADDR_SCAN_NEXT: addr = {chain_r[IDX_W-1:0], col_plus};
      default:        addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= in_entry_value;
    end
    if (cmd.mem_re) begin
      rd_data_r <= mem[addr];
    end
  end

  always_comb begin
    chain_nxt = cmd.chain_ld ? rd_data_r : chain_r;
    priority if (cmd.col_clr) begin
      col_nxt = '0;
    end else if (cmd.col_inc) begin
      col_nxt = col_plus;
    end else begin
      col_nxt = col_r;
    end
    res_byte_nxt  = res_byte_r;
    res_match_nxt = res_match_r;
    priority if (cmd.res_enc) begin
      res_byte_nxt  = rd_data_r;
      res_match_nxt = 1'b1;
    end else if (cmd.res_hit) begin
      res_byte_nxt  = BYTE_W'(col_r);
      res_match_nxt = 1'b1;
    end else if (cmd.res_miss) begin
      res_byte_nxt  = '0;
      res_match_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else begin
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    res_byte_r  <= res_byte_nxt;
    res_match_r <= res_match_nxt;
    if (cmd.latch_in) begin
      data_r <= in_data_byte;
    end
    if (cmd.out_load) begin
      out_byte_r  <= res_byte_r;
      out_match_r <= res_match_r;
    end
  end

  assign status.hit      = (rd_data_r == data_r);
  assign status.last_col = (col_r == IDX_W'(TABLE_SIDE - 1));
  assign out_byte        = out_byte_r;
  assign out_matched     = out_match_r;

endmodule

// ----- rtl/core/chained_table_substitution_cipher_core.sv -----
// Top level of the chained table substitution cipher core.
//
//   Channel | Direction | Handshake          | Word
//   in_     | input     | in_valid / in_stall | opcode, row, column, value, seed, data
//   out_    | output    | out_valid/out_stall | out_byte, matched
//
// A key write completes in the idle state; begin passes through ST_LOAD, and encrypt
// through ST_ENC and ST_FINISH, before the next word is taken. Decrypt scans the
// chain row one table entry per cycle through the single memory port, reading at most TABLE_SIDE columns.
// Synchronous active-low reset clears the chain symbol and control; the key
// table holds nothing defined until written.
// A finished result waits in the output register; a later word is still taken,
// and only the next result waits for that register to drain.
module chained_table_substitution_cipher_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_table_row,
  input  logic [7:0] in_table_column,
  input  logic [7:0] in_entry_value,
  input  logic [7:0] in_seed,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_matched
);
  import ctsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  ctsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ctsc_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_table_row    (in_table_row),
    .in_table_column (in_table_column),
    .in_entry_value  (in_entry_value),
    .in_seed         (in_seed),
    .in_data_byte    (in_data_byte),
    .status          (status),
    .out_byte        (out_byte),
    .out_matched     (out_matched)
  );

endmodule

// ----- rtl/core/ctsc_checker.sv -----
// Port-level checker for the cipher core, bound to the top level.
module ctsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_opcode,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_matched
);
  import ctsc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_matched))
    else $error("result word changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_byte == 8'd0)
    else $error("failed search must give zero");

  // no result can appear the cycle after a word is taken
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_busy_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_ENCRYPT || in_opcode == OP_DECRYPT) |=> in_stall)
    else $error("input not stalled during lookup");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind chained_table_substitution_cipher_core ctsc_checker u_ctsc_checker (.*);
